[rtl/q7_8_complex_fixed_point_alu_macros.svh]
// Assertion macros used by the checker of the Q7.8 complex arithmetic unit.
`ifndef Q7_8_COMPLEX_FIXED_POINT_ALU_MACROS_SVH
`define Q7_8_COMPLEX_FIXED_POINT_ALU_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define Q78CX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define Q78CX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/q78cx_pkg.sv]
// Package with operation codes, constants and stage payload types of the Q7.8 unit.
`timescale 1ns / 1ps

package q78cx_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_CADD    = 3'd3,
        OP_CSUB    = 3'd4,
        OP_CMUL    = 3'd5,
        OP_F2X     = 3'd6,
        OP_X2F     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        F2X_ZERO = 2'd0,
        F2X_SAT  = 2'd1,
        F2X_NORM = 2'd2
    } f2x_class_t;

    localparam logic [15:0] Q_MAX          = 16'h7FFF;
    localparam logic [15:0] Q_MIN          = 16'h8000;
    localparam logic [7:0]  EXP_SPECIAL    = 8'hFF;
    localparam logic [7:0]  F2X_EXP_LIMIT  = 8'd142;
    localparam logic [7:0]  F2X_SHIFT_MAX  = 8'd25;
    localparam logic [7:0]  X2F_EXP_OFFSET = 8'd119;
    localparam logic [4:0]  X2F_TOP_BIT    = 5'd23;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] p_rr;
        logic signed [31:0] p_ii;
        logic signed [31:0] p_ri;
        logic signed [31:0] p_ir;
        logic [15:0]        sum_re;
        logic [15:0]        sum_im;
        f2x_class_t         f_class;
        logic               f_neg;
        logic [23:0]        f_t;
        logic               x_neg;
        logic [15:0]        x_mag;
        logic [3:0]         x_p;
    } s1_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] q_rr;
        logic [15:0] q_ii;
        logic [15:0] q_ri;
        logic [15:0] q_ir;
        logic [15:0] sum_re;
        logic [15:0] sum_im;
        logic [15:0] f2x_val;
        logic [31:0] float_bits;
    } s2_t;

endpackage

[rtl/q78cx_front.sv]
// First pipeline stage: products, add and subtract, and decoding for both conversions.
`timescale 1ns / 1ps

module q78cx_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  q78cx_pkg::op_t     op,
    input  logic signed [15:0] a_real,
    input  logic signed [15:0] a_imag,
    input  logic signed [15:0] b_real,
    input  logic signed [15:0] b_imag,
    input  logic [31:0]        float_in,
    output logic               out_valid,
    input  logic               out_ready,
    output q78cx_pkg::s1_t     out_data
);

    logic           valid_reg;
    q78cx_pkg::s1_t data_reg;
    q78cx_pkg::s1_t data_next;

    logic [7:0]  exp_raw;
    logic [22:0] man_raw;
    logic [23:0] sig;
    logic [7:0]  exp_adj;
    logic [7:0]  shift;
    logic [4:0]  shift_m1;
    logic [15:0] mag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign exp_raw  = float_in[30:23];
    assign man_raw  = float_in[22:0];
    assign sig      = (exp_raw == 8'd0) ? {1'b0, man_raw} : {1'b1, man_raw};
    assign exp_adj  = (exp_raw == 8'd0) ? 8'd1 : exp_raw;
    assign shift    = q78cx_pkg::F2X_EXP_LIMIT - exp_adj;
    assign shift_m1 = 5'(shift - 8'd1);
    assign mag      = a_real[15] ? 16'(-a_real) : 16'(a_real);

    always_comb
    begin
        data_next         = '0;
        data_next.op      = op;
        data_next.p_rr    = a_real * b_real;
        data_next.p_ii    = a_imag * b_imag;
        data_next.p_ri    = a_real * b_imag;
        data_next.p_ir    = a_imag * b_real;
        if (op == q78cx_pkg::OP_SUB || op == q78cx_pkg::OP_CSUB)
        begin
            data_next.sum_re = 16'(a_real - b_real);
            data_next.sum_im = 16'(a_imag - b_imag);
        end
        else
        begin
            data_next.sum_re = 16'(a_real + b_real);
            data_next.sum_im = 16'(a_imag + b_imag);
        end

        data_next.f_neg = float_in[31];
        data_next.f_t   = sig >> shift_m1;
        if (exp_raw == q78cx_pkg::EXP_SPECIAL)
        begin
            data_next.f_class = (man_raw != 23'd0) ? q78cx_pkg::F2X_ZERO : q78cx_pkg::F2X_SAT;
        end
        else if (exp_adj >= q78cx_pkg::F2X_EXP_LIMIT)
        begin
            data_next.f_class = (sig == 24'd0) ? q78cx_pkg::F2X_ZERO : q78cx_pkg::F2X_SAT;
        end
        else if (shift >= q78cx_pkg::F2X_SHIFT_MAX)
        begin
            data_next.f_class = q78cx_pkg::F2X_ZERO;
        end
        else
        begin
            data_next.f_class = q78cx_pkg::F2X_NORM;
        end

        data_next.x_neg = a_real[15];
        data_next.x_mag = mag;
        data_next.x_p   = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (mag[i])
            begin
                data_next.x_p = 4'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/q78cx_mid.sv]
// Second pipeline stage: product saturation, float rounding and float packing.
`timescale 1ns / 1ps

module q78cx_mid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  q78cx_pkg::s1_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output q78cx_pkg::s2_t out_data
);

    logic           valid_reg;
    q78cx_pkg::s2_t data_reg;
    q78cx_pkg::s2_t data_next;

    logic [23:0] f_mag;
    logic [7:0]  x_exp;
    logic [4:0]  x_shamt;
    logic [23:0] x_norm;

    // Floor shift by eight fraction bits, then clamp to the Q7.8 range.
    function automatic logic [15:0] sat_product(input logic signed [31:0] p);
        logic [15:0] r;
        if (p[31:23] == 9'h000 || p[31:23] == 9'h1FF)
        begin
            r = p[23:8];
        end
        else
        begin
            r = p[31] ? q78cx_pkg::Q_MIN : q78cx_pkg::Q_MAX;
        end
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign f_mag   = 24'(({1'b0, in_data.f_t} + 25'd1) >> 1);
    assign x_exp   = {4'd0, in_data.x_p} + q78cx_pkg::X2F_EXP_OFFSET;
    assign x_shamt = q78cx_pkg::X2F_TOP_BIT - {1'b0, in_data.x_p};
    assign x_norm  = {8'd0, in_data.x_mag} << x_shamt;

    always_comb
    begin
        data_next        = '0;
        data_next.op     = in_data.op;
        data_next.q_rr   = sat_product(in_data.p_rr);
        data_next.q_ii   = sat_product(in_data.p_ii);
        data_next.q_ri   = sat_product(in_data.p_ri);
        data_next.q_ir   = sat_product(in_data.p_ir);
        data_next.sum_re = in_data.sum_re;
        data_next.sum_im = in_data.sum_im;

        case (in_data.f_class)
            q78cx_pkg::F2X_SAT:
            begin
                data_next.f2x_val = in_data.f_neg ? q78cx_pkg::Q_MIN : q78cx_pkg::Q_MAX;
            end
            q78cx_pkg::F2X_NORM:
            begin
                if (in_data.f_neg)
                begin
                    data_next.f2x_val = (f_mag > 24'd32768) ? q78cx_pkg::Q_MIN
                                                             : 16'(-f_mag[15:0]);
                end
                else
                begin
                    data_next.f2x_val = (f_mag > 24'd32767) ? q78cx_pkg::Q_MAX : f_mag[15:0];
                end
            end
            default:
            begin
                data_next.f2x_val = 16'd0;
            end
        endcase

        if (in_data.x_mag == 16'd0)
        begin
            data_next.float_bits = 32'd0;
        end
        else
        begin
            data_next.float_bits = {in_data.x_neg, x_exp, x_norm[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/q78cx_back.sv]
// Third pipeline stage: complex combine, result selection and the output register.
`timescale 1ns / 1ps

module q78cx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  q78cx_pkg::s2_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] result_real,
    output logic signed [15:0] result_imag,
    output logic [31:0]        float_out
);

    logic        valid_reg;
    logic [15:0] re_reg;
    logic [15:0] re_next;
    logic [15:0] im_reg;
    logic [15:0] im_next;
    logic [31:0] fo_reg;
    logic [31:0] fo_next;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign result_real = re_reg;
    assign result_imag = im_reg;
    assign float_out   = fo_reg;

    always_comb
    begin
        re_next = 16'd0;
        im_next = 16'd0;
        fo_next = 32'd0;
        case (in_data.op)
            q78cx_pkg::OP_ADD, q78cx_pkg::OP_SUB:
            begin
                re_next = in_data.sum_re;
            end
            q78cx_pkg::OP_MUL:
            begin
                re_next = in_data.q_rr;
            end
            q78cx_pkg::OP_CADD, q78cx_pkg::OP_CSUB:
            begin
                re_next = in_data.sum_re;
                im_next = in_data.sum_im;
            end
            q78cx_pkg::OP_CMUL:
            begin
                re_next = in_data.q_rr - in_data.q_ii;
                im_next = in_data.q_ri + in_data.q_ir;
            end
            q78cx_pkg::OP_F2X:
            begin
                re_next = in_data.f2x_val;
            end
            q78cx_pkg::OP_X2F:
            begin
                fo_next = in_data.float_bits;
            end
            default:
            begin
                re_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            fo_reg <= fo_next;
        end
    end

endmodule

[rtl/q7_8_complex_fixed_point_alu.sv]
// Top level of the pipelined signed Q7.8 complex arithmetic unit.
`timescale 1ns / 1ps

// The input channel (in_valid, in_ready) takes one item per cycle when not stalled:
// an operation code, two complex Q7.8 operands and an IEEE single pattern. The output
// channel (out_valid, out_ready) returns one result item for each input item, in order.
// An item accepted into the front stage register passes the mid stage register
// and shows from the back stage output register; throughput is one item per
// cycle while out_ready stays high. The three stages are: the four 16x16
// multipliers with operand decoding, the product saturation with float rounding
// and packing, and the complex combine with the output register.
// Each stage holds its own valid bit and is ready when empty or when the next
// stage moves, so a stalled receiver backs the pipeline up stage by stage and
// bubbles are squeezed out; in_ready falls only when all three stages are full.
// Reset clears the valid bits, so no item is offered after reset.

module q7_8_complex_fixed_point_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [15:0] a_real,
    input  logic signed [15:0] a_imag,
    input  logic signed [15:0] b_real,
    input  logic signed [15:0] b_imag,
    input  logic [31:0]        float_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] result_real,
    output logic signed [15:0] result_imag,
    output logic [31:0]        float_out
);

    logic           s1_valid;
    logic           s1_ready;
    q78cx_pkg::s1_t s1_data;
    logic           s2_valid;
    logic           s2_ready;
    q78cx_pkg::s2_t s2_data;

    q78cx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (q78cx_pkg::op_t'(operation)),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .float_in  (float_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    q78cx_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    q78cx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s2_valid),
        .in_ready    (s2_ready),
        .in_data     (s2_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_real (result_real),
        .result_imag (result_imag),
        .float_out   (float_out)
    );

endmodule

[rtl/q78cx_checker.sv]
// Port-level checker of the Q7.8 complex arithmetic unit and its bind statement.
`timescale 1ns / 1ps
`include "q7_8_complex_fixed_point_alu_macros.svh"

module q78cx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] result_real,
    input logic signed [15:0] result_imag,
    input logic [31:0]        float_out
);

    `Q78CX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "Result offered after reset")
    `Q78CX_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(result_real) && $stable(result_imag) && $stable(float_out)), "Stalled item changed")
    `Q78CX_ASSERT(a_empty_ready, !out_valid |-> in_ready, "Input refused with empty pipeline")
    `Q78CX_ASSERT(a_float_alone, (out_valid && float_out != 32'd0) |-> (result_real == 16'sd0 && result_imag == 16'sd0), "Float result with fixed fields set")

endmodule

bind q7_8_complex_fixed_point_alu q78cx_checker u_checker (.*);
